// File: hw/rtl/skifb_pkg.sv
package skifb_pkg;

    // field and counter widths
    localparam int DIM_W  = 13;
    localparam int CNT_W  = 26;
    localparam int PIX_W  = 8;
    localparam int WORD_W = 4 * PIX_W;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // register indexes
    localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

    // commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Gaussian weights (normalized weights times 250000), by distance class
    localparam logic [25:0] GW_CTR  = 26'd62279;
    localparam logic [25:0] GW_AX1  = 26'd28514;
    localparam logic [25:0] GW_DG1  = 26'd13054;
    localparam logic [25:0] GW_AX2  = 26'd2736;
    localparam logic [25:0] GW_KN   = 26'd1253;
    localparam logic [25:0] GW_DG2  = 26'd120;
    localparam logic [26:0] GDIV    = 27'd250000;
    localparam logic [12:0] GREC    = 13'd4294;
    localparam logic [15:0] DIV5_M  = 16'd52429;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             wr;
        logic             emit;
        logic             ok3;
        logic             ok5;
        logic             last;
        logic [DIM_W-1:0] col;
    } t_job;

    function automatic logic [PIX_W-1:0] clamp8(input logic signed [12:0] v);
        logic [PIX_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 13'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/skifb_if.sv
interface skifb_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] pixel_value;
    modport source(output valid, command, pixel_value, input ready);
    modport sink(input valid, command, pixel_value, output ready);
endinterface

interface skifb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cross_mean;
    logic [7:0] diagonal_mean;
    logic [7:0] laplacian;
    logic [7:0] sharpened;
    logic [7:0] embossed;
    logic [7:0] gaussian;
    logic       frame_last;
    modport source(output valid, cross_mean, diagonal_mean, laplacian, sharpened,
                   embossed, gaussian, frame_last, input ready);
    modport sink(input valid, cross_mean, diagonal_mean, laplacian, sharpened,
                 embossed, gaussian, frame_last, output ready);
endinterface

// File: hw/rtl/skifb_fifo.sv
module skifb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  skifb_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output skifb_pkg::t_job o_job
);
    skifb_pkg::t_job              r_q [skifb_pkg::QDEPTH];
    logic [skifb_pkg::QAW-1:0]    r_wp;
    logic [skifb_pkg::QAW-1:0]    r_rp;
    logic [skifb_pkg::QAW:0]      r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_cnt == (skifb_pkg::QAW+1)'(skifb_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (!do_push && do_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // hold queued requests
    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= i_job;
    end
endmodule

// File: hw/rtl/skifb_front.sv
module skifb_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    skifb_in_if.sink                      i_in,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [skifb_pkg::DIM_W-1:0]   i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output skifb_pkg::t_job               o_job
);
    localparam int RST_WI = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
    localparam int RST_HI = (512 > MAX_HEIGHT) ? MAX_HEIGHT : 512;
    localparam logic [skifb_pkg::DIM_W-1:0] RST_W = skifb_pkg::DIM_W'(RST_WI);
    localparam logic [skifb_pkg::DIM_W-1:0] RST_H = skifb_pkg::DIM_W'(RST_HI);
    localparam logic [skifb_pkg::CNT_W-1:0] RST_T = skifb_pkg::CNT_W'(RST_WI * RST_HI);
    localparam logic [skifb_pkg::CNT_W-1:0] RST_L = skifb_pkg::CNT_W'(2 * RST_WI + 2);

    logic [skifb_pkg::DIM_W-1:0] r_w, r_h;
    logic [skifb_pkg::CNT_W-1:0] r_total, r_lag;
    logic                        r_cfg_busy;
    logic [skifb_pkg::CNT_W-1:0] r_n_in, r_n_out, r_pend;
    logic [skifb_pkg::DIM_W-1:0] r_or, r_oc, r_sc;

    logic                        fire, pix_cmd, in_done, pix_ok, emit, last, push;
    logic                        ok3, ok5;
    logic [skifb_pkg::CNT_W-1:0] n_pend;
    logic [skifb_pkg::DIM_W:0]   or_x, oc_x, h_x, w_x;

    function automatic logic [skifb_pkg::DIM_W-1:0] sat_dim(
        input logic [skifb_pkg::DIM_W-1:0] v, input int maxv);
        logic [skifb_pkg::DIM_W-1:0] r;
        if (v == '0) begin
            r = skifb_pkg::DIM_W'(1);
        end else if (int'(v) > maxv) begin
            r = skifb_pkg::DIM_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign i_in.ready = !i_q_full && !r_cfg_busy;
    assign fire       = i_in.valid && i_in.ready;

    // classify the request
    always_comb begin
        pix_cmd = (i_in.command == skifb_pkg::CMD_PIXEL);
        in_done = (r_n_in == r_total);
        pix_ok  = pix_cmd && !in_done;
        if (pix_cmd) begin
            emit = pix_ok && ((r_pend + 1'b1) > r_lag);
        end else begin
            emit = in_done && (r_pend != '0);
        end
        last   = ((r_n_out + 1'b1) == r_total);
        push   = fire && (pix_ok || emit);
        n_pend = r_pend + skifb_pkg::CNT_W'(pix_ok) - skifb_pkg::CNT_W'(emit);
        or_x   = {1'b0, r_or};
        oc_x   = {1'b0, r_oc};
        h_x    = {1'b0, r_h};
        w_x    = {1'b0, r_w};
        ok3    = (r_or >= 1) && (or_x + 2'd2 <= h_x) && (r_oc >= 1) && (oc_x + 2'd2 <= w_x);
        ok5    = (r_or >= 2) && (or_x + 2'd3 <= h_x) && (r_oc >= 2) && (oc_x + 2'd3 <= w_x);
    end

    assign o_push       = push;
    assign o_job.pix    = pix_cmd ? i_in.pixel_value : '0;
    assign o_job.wr     = pix_ok;
    assign o_job.emit   = emit;
    assign o_job.ok3    = ok3;
    assign o_job.ok5    = ok5;
    assign o_job.last   = last;
    assign o_job.col    = r_sc;

    // track frame geometry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= RST_W;
            r_h        <= RST_H;
            r_total    <= RST_T;
            r_lag      <= RST_L;
            r_cfg_busy <= 1'b0;
        end else begin
            r_total    <= skifb_pkg::CNT_W'(r_w) * skifb_pkg::CNT_W'(r_h);
            r_lag      <= skifb_pkg::CNT_W'({r_w, 1'b0}) + 2'd2;
            r_cfg_busy <= i_cfg_we;
            if (i_cfg_we) begin
                if (i_cfg_idx == skifb_pkg::CFG_IDX_WIDTH) r_w <= sat_dim(i_cfg_data, MAX_WIDTH);
                else r_h <= sat_dim(i_cfg_data, MAX_HEIGHT);
            end
        end
    end

    // advance raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (fire && emit && last)) begin
            r_n_in  <= '0;
            r_n_out <= '0;
            r_pend  <= '0;
            r_or    <= '0;
            r_oc    <= '0;
            r_sc    <= '0;
        end else if (fire) begin
            if (pix_ok) r_n_in <= r_n_in + 1'b1;
            r_pend <= n_pend;
            if (emit) begin
                r_n_out <= r_n_out + 1'b1;
                if (r_oc + 1'b1 == r_w) begin
                    r_oc <= '0;
                    r_or <= r_or + 1'b1;
                end else begin
                    r_oc <= r_oc + 1'b1;
                end
            end
            if (push) begin
                r_sc <= (r_sc + 1'b1 == r_w) ? '0 : r_sc + 1'b1;
            end
        end
    end
endmodule

// File: hw/rtl/skifb_back.sv
module skifb_back #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  skifb_pkg::t_job i_q_job,
    output logic            o_q_pop,
    skifb_out_if.source     o_out
);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [skifb_pkg::WORD_W-1:0] r_mem [MAX_WIDTH];
    logic                         en;

    // stage 1: column word read
    logic                         r_v1;
    skifb_pkg::t_job              r_j1;
    logic [skifb_pkg::WORD_W-1:0] r_rd, r_fwd_word, rdf, n_word;
    logic                         r_fwd;

    // stage 2: window
    logic [7:0]                   r_win [5][5];
    logic                         r_v2, r_ok3_2, r_ok5_2, r_last2;

    // stage 3: sums
    logic                         r_v3, r_ok3_3, r_ok5_3, r_last3;
    logic [10:0]                  r_cross3, r_diag3;
    logic signed [12:0]           r_lap3, r_shp3, r_emb3;
    logic [7:0]                   r_ga3;
    logic [9:0]                   r_gb3, r_gc3, r_gd3, r_gf3;
    logic [10:0]                  r_ge3;

    // stage 4: scaled
    logic                         r_v4, r_ok5_4, r_last4;
    logic [7:0]                   r_cross4, r_diag4, r_lap4, r_shp4, r_emb4;
    logic [25:0]                  r_g4;

    // stage 5: quotient estimate
    logic                         r_v5, r_ok5_5, r_last5;
    logic [7:0]                   r_cross5, r_diag5, r_lap5, r_shp5, r_emb5;
    logic [25:0]                  r_g5;
    logic [8:0]                   r_q5;

    // output register
    logic                         r_o_valid, r_o_last;
    logic [7:0]                   r_o_cross, r_o_diag, r_o_lap, r_o_shp, r_o_emb, r_o_gau;

    // combinational per stage
    logic [10:0]                  s_cross, s_ring, s_diag;
    logic [10:0]                  s_ge;
    logic [9:0]                   s_gb, s_gc, s_gd, s_gf;
    logic signed [12:0]           s_lap, s_shp, s_emb;
    logic [26:0]                  m_cross, m_diag;
    logic [25:0]                  m_g;
    logic [38:0]                  m_q;
    logic [26:0]                  m_rem;
    logic [9:0]                   m_qf;

    assign en      = !r_o_valid || o_out.ready;
    assign o_q_pop = en && i_q_valid;

    // column word read and write-back
    assign rdf    = r_fwd ? r_fwd_word : r_rd;
    assign n_word = {rdf[23:0], r_j1.pix};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd <= r_mem[AW'(i_q_job.col)];
            if (r_v1 && r_j1.wr) r_mem[AW'(r_j1.col)] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j1       <= i_q_job;
            r_fwd      <= r_v1 && r_j1.wr && (r_j1.col == i_q_job.col);
            r_fwd_word <= n_word;
        end
    end

    // shift the window one column
    always_ff @(posedge i_clk) begin
        if (en && r_v1) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
            end
            r_win[0][4] <= rdf[31:24];
            r_win[1][4] <= rdf[23:16];
            r_win[2][4] <= rdf[15:8];
            r_win[3][4] <= rdf[7:0];
            r_win[4][4] <= r_j1.pix;
        end
    end

    // form window sums
    always_comb begin
        s_ring = 11'(r_win[1][1]) + 11'(r_win[1][2]) + 11'(r_win[1][3]) + 11'(r_win[2][1])
               + 11'(r_win[2][3]) + 11'(r_win[3][1]) + 11'(r_win[3][2]) + 11'(r_win[3][3]);
        s_cross = 11'(r_win[1][2]) + 11'(r_win[2][1]) + 11'(r_win[2][2]) + 11'(r_win[2][3])
                + 11'(r_win[3][2]);
        s_diag = 11'(r_win[0][0]) + 11'(r_win[1][1]) + 11'(r_win[2][2]) + 11'(r_win[3][3])
               + 11'(r_win[4][4]);
        s_lap = $signed({2'b00, r_win[2][2], 3'b000}) - $signed({2'b00, s_ring});
        s_shp = s_lap + $signed({5'b00000, r_win[2][2]});
        s_emb = $signed(13'(r_win[2][3])) + $signed(13'(r_win[3][2]))
              + $signed(13'(r_win[3][3])) - $signed(13'(r_win[1][1]))
              - $signed(13'(r_win[1][2])) - $signed(13'(r_win[2][1]));
        s_gb = 10'(r_win[1][2]) + 10'(r_win[2][1]) + 10'(r_win[2][3]) + 10'(r_win[3][2]);
        s_gc = 10'(r_win[1][1]) + 10'(r_win[1][3]) + 10'(r_win[3][1]) + 10'(r_win[3][3]);
        s_gd = 10'(r_win[0][2]) + 10'(r_win[2][0]) + 10'(r_win[2][4]) + 10'(r_win[4][2]);
        s_ge = 11'(r_win[0][1]) + 11'(r_win[0][3]) + 11'(r_win[1][0]) + 11'(r_win[1][4])
             + 11'(r_win[3][0]) + 11'(r_win[3][4]) + 11'(r_win[4][1]) + 11'(r_win[4][3]);
        s_gf = 10'(r_win[0][0]) + 10'(r_win[0][4]) + 10'(r_win[4][0]) + 10'(r_win[4][4]);
    end

    // scale, weight and clamp
    always_comb begin
        m_cross = 27'(r_cross3) * 27'(skifb_pkg::DIV5_M);
        m_diag  = 27'(r_diag3) * 27'(skifb_pkg::DIV5_M);
        m_g = 26'(r_ga3) * skifb_pkg::GW_CTR + 26'(r_gb3) * skifb_pkg::GW_AX1
            + 26'(r_gc3) * skifb_pkg::GW_DG1 + 26'(r_gd3) * skifb_pkg::GW_AX2
            + 26'(r_ge3) * skifb_pkg::GW_KN  + 26'(r_gf3) * skifb_pkg::GW_DG2;
        m_q   = 39'(r_g4) * 39'(skifb_pkg::GREC);
        m_rem = 27'(r_g5) - 27'(r_q5) * skifb_pkg::GDIV;
        m_qf  = (m_rem >= skifb_pkg::GDIV) ? 10'(r_q5) + 1'b1 : 10'(r_q5);
    end

    // advance the arithmetic pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_v2      <= r_v1 && r_j1.emit;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_o_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok3_2  <= r_j1.ok3;
            r_ok5_2  <= r_j1.ok5;
            r_last2  <= r_j1.last;

            r_ok3_3  <= r_ok3_2;
            r_ok5_3  <= r_ok5_2;
            r_last3  <= r_last2;
            r_cross3 <= s_cross;
            r_diag3  <= s_diag;
            r_lap3   <= s_lap;
            r_shp3   <= s_shp;
            r_emb3   <= s_emb;
            r_ga3    <= r_win[2][2];
            r_gb3    <= s_gb;
            r_gc3    <= s_gc;
            r_gd3    <= s_gd;
            r_ge3    <= s_ge;
            r_gf3    <= s_gf;

            r_ok5_4  <= r_ok5_3;
            r_last4  <= r_last3;
            r_cross4 <= r_ok3_3 ? m_cross[25:18] : '0;
            r_diag4  <= r_ok5_3 ? m_diag[25:18] : '0;
            r_lap4   <= r_ok3_3 ? skifb_pkg::clamp8(r_lap3) : '0;
            r_shp4   <= r_ok3_3 ? skifb_pkg::clamp8(r_shp3) : '0;
            r_emb4   <= r_ok3_3 ? skifb_pkg::clamp8(r_emb3) : '0;
            r_g4     <= m_g;

            r_ok5_5  <= r_ok5_4;
            r_last5  <= r_last4;
            r_cross5 <= r_cross4;
            r_diag5  <= r_diag4;
            r_lap5   <= r_lap4;
            r_shp5   <= r_shp4;
            r_emb5   <= r_emb4;
            r_g5     <= r_g4;
            r_q5     <= m_q[38:30];

            r_o_last  <= r_last5;
            r_o_cross <= r_cross5;
            r_o_diag  <= r_diag5;
            r_o_lap   <= r_lap5;
            r_o_shp   <= r_shp5;
            r_o_emb   <= r_emb5;
            if (!r_ok5_5) r_o_gau <= '0;
            else if (m_qf > 10'd255) r_o_gau <= 8'd255;
            else r_o_gau <= m_qf[7:0];
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.cross_mean    = r_o_cross;
    assign o_out.diagonal_mean = r_o_diag;
    assign o_out.laplacian     = r_o_lap;
    assign o_out.sharpened     = r_o_shp;
    assign o_out.embossed      = r_o_emb;
    assign o_out.gaussian      = r_o_gau;
    assign o_out.frame_last    = r_o_last;
endmodule

// File: hw/rtl/six_kernel_image_filter_bank.sv
// Six-kernel 3x3/5x5 filter bank on a raster stream of 8-bit pixels.
// Input channel i_in carries requests: command pixel (with pixel_value) or
// command drain. Output channel o_out carries one result of six filtered
// bytes plus frame_last. Both use valid/ready; a request or result moves
// when both are high. The result for a pixel is released by the request that
// brings the pixel two rows and two columns later; after the frame's last
// pixel, each drain request releases one pending result.
// Throughput: one request per cycle while i_in.ready is high. A request goes
// through a four-entry queue, then one column-store read (one read and one
// write port, one column word per request), the window shift and four
// arithmetic stages before a released result appears. Width and height are
// written on the i_cfg port, by the user only while the block is idle, which
// the block does not enforce. A write restarts the frame and i_in.ready drops
// for the cycle after it. Reset restores 512x512 (limited to the maximum
// size), clears the counters, the queue and the pipeline; the column store
// needs no clearing. When o_out.ready is low the whole back pipeline holds;
// the queue keeps taking requests until it fills, then i_in.ready drops.
module six_kernel_image_filter_bank #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    skifb_in_if.sink                    i_in,
    skifb_out_if.source                 o_out,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [skifb_pkg::DIM_W-1:0] i_cfg_data
);
    logic            q_push, q_full, q_valid, q_pop;
    skifb_pkg::t_job q_in_job, q_out_job;

    skifb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (q_in_job)
    );

    skifb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    skifb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_out_job),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_in.ready)
        else $error("request taken right after a configuration write");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && !q_push) |=> ($past(q_valid)))
        else $error("queue popped while empty");
`endif
endmodule
